>>> design/kcl_pkg.sv
package kcl_pkg;

    // Entry store size
    localparam int MAX_KEYS_DEFAULT = 16;

    // Fixed field widths
    localparam int KEY_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int FAIL_W      = 4;
    localparam int CODE_W      = 64;
    localparam int BLINK_W     = 16;
    localparam int ALARM_W     = 20;
    localparam int CFG_INDEX_W = 3;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd14;
    localparam logic [KEY_W-1:0] KEY_ENTER = 4'd15;

    // Item modes
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

    // Configuration reset values
    localparam logic [CODE_W-1:0]  CODE_KEYS_RST     = 64'h4321;
    localparam logic [COUNT_W-1:0] CODE_LENGTH_RST   = 5'd4;
    localparam logic [FAIL_W-1:0]  ATTEMPT_LIMIT_RST = 4'd3;
    localparam logic [BLINK_W-1:0] BLINK_TICKS_RST   = 16'd500;
    localparam logic [ALARM_W-1:0] ALARM_TICKS_RST   = 20'd30000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CODE_KEYS     = 3'd0,
        CFG_CODE_LENGTH   = 3'd1,
        CFG_ATTEMPT_LIMIT = 3'd2,
        CFG_BLINK_TICKS   = 3'd3,
        CFG_ALARM_TICKS   = 3'd4
    } cfg_index_t;

    // Entry unit -> alarm unit
    typedef struct packed {
        logic tick;
        logic granted;
        logic denied;
    } kcl_event_t;

    // Alarm unit -> result stage
    typedef struct packed {
        logic              first_warning;
        logic              alarm_started;
        logic              alarm_ended;
        logic              alarm_on;
        logic              alarm_led;
        logic [FAIL_W-1:0] failure_count;
    } kcl_status_t;

endpackage

>>> design/kcl_in_if.sv
interface kcl_in_if;
    import kcl_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output mode, output key_code, input ready);
    modport sink   (input valid, input mode, input key_code, output ready);
endinterface

>>> design/kcl_out_if.sv
interface kcl_out_if;
    import kcl_pkg::*;

    logic               valid;
    logic               ready;
    logic               granted;
    logic               denied;
    logic               first_warning;
    logic               alarm_started;
    logic               alarm_ended;
    logic               alarm_on;
    logic               alarm_led;
    logic               key_dropped;
    logic [COUNT_W-1:0] entered_count;
    logic [FAIL_W-1:0]  failure_count;

    modport source (
        output valid, output granted, output denied, output first_warning,
        output alarm_started, output alarm_ended, output alarm_on, output alarm_led,
        output key_dropped, output entered_count, output failure_count,
        input ready
    );
    modport sink (
        input valid, input granted, input denied, input first_warning,
        input alarm_started, input alarm_ended, input alarm_on, input alarm_led,
        input key_dropped, input entered_count, input failure_count,
        output ready
    );
endinterface

>>> design/keypad_code_lock_with_alarm.sv
// An input transfer is held in the input register, passes through the update
// logic into the result register and transfers out from there. Throughput: one
// item per cycle; the input register, the single-pass update logic and the result
// register let a new key or tick follow every cycle while results are taken.
// Reset (rst_n, async, active low): entry length, failure count and alarm state
// clear, configuration returns to its defaults, both channel registers go empty.
// The entry key store itself is not reset; only entries below the length are read.
module keypad_code_lock_with_alarm #(
    parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kcl_in_if.sink                          events,
    kcl_out_if.source                       results,
    input  logic                            cfg_we,
    input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kcl_pkg::CODE_W-1:0]      cfg_data
);
    import kcl_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers; the user writes them only while the block is idle (unchecked)
    // ---------------------------------------------------------------
    logic [CODE_W-1:0]  code_keys_reg;
    logic [COUNT_W-1:0] code_length_reg;
    logic [FAIL_W-1:0]  attempt_limit_reg;
    logic [BLINK_W-1:0] blink_ticks_reg;
    logic [ALARM_W-1:0] alarm_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_keys_reg     <= CODE_KEYS_RST;
            code_length_reg   <= CODE_LENGTH_RST;
            attempt_limit_reg <= ATTEMPT_LIMIT_RST;
            blink_ticks_reg   <= BLINK_TICKS_RST;
            alarm_ticks_reg   <= ALARM_TICKS_RST;
        end
        else if (cfg_we)
        begin
            // indexes past the list are ignored
            unique case (cfg_index_t'(cfg_index))
                CFG_CODE_KEYS:     code_keys_reg     <= cfg_data;
                CFG_CODE_LENGTH:   code_length_reg   <= cfg_data[COUNT_W-1:0];
                CFG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data[FAIL_W-1:0];
                CFG_BLINK_TICKS:   blink_ticks_reg   <= cfg_data[BLINK_W-1:0];
                CFG_ALARM_TICKS:   alarm_ticks_reg   <= cfg_data[ALARM_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register. fire = the held item goes through the update logic
    // this cycle, which needs the result register free or being drained.
    // ---------------------------------------------------------------
    logic             ev_valid_reg;
    logic             ev_valid_next;
    logic             ev_mode_reg;
    logic [KEY_W-1:0] ev_key_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             fire;
    logic             ev_take;

    assign fire          = ev_valid_reg && (!res_valid_reg || results.ready);
    assign events.ready  = !ev_valid_reg || fire;
    assign ev_take       = events.valid && events.ready;
    assign ev_valid_next = ev_take || (ev_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            ev_mode_reg <= events.mode;
            ev_key_reg  <= events.key_code;
        end
    end

    // ---------------------------------------------------------------
    // Update logic: entry store and compare, then failure/alarm state
    // ---------------------------------------------------------------
    kcl_event_t         evt;
    kcl_status_t        status;
    logic               dropped;
    logic [COUNT_W-1:0] entered;

    kcl_entry #(
        .MAX_KEYS (MAX_KEYS)
    ) u_entry (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .mode          (ev_mode_reg),
        .key_code      (ev_key_reg),
        .code_keys     (code_keys_reg),
        .code_length   (code_length_reg),
        .evt           (evt),
        .key_dropped   (dropped),
        .entered_count (entered)
    );

    kcl_alarm u_alarm (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .evt           (evt),
        .attempt_limit (attempt_limit_reg),
        .blink_ticks   (blink_ticks_reg),
        .alarm_ticks   (alarm_ticks_reg),
        .status        (status)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic               granted_reg;
    logic               denied_reg;
    kcl_status_t        status_reg;
    logic               dropped_reg;
    logic [COUNT_W-1:0] entered_reg;

    assign res_valid_next = fire || (res_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            granted_reg <= evt.granted;
            denied_reg  <= evt.denied;
            status_reg  <= status;
            dropped_reg <= dropped;
            entered_reg <= entered;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.granted       = granted_reg;
    assign results.denied        = denied_reg;
    assign results.first_warning = status_reg.first_warning;
    assign results.alarm_started = status_reg.alarm_started;
    assign results.alarm_ended   = status_reg.alarm_ended;
    assign results.alarm_on      = status_reg.alarm_on;
    assign results.alarm_led     = status_reg.alarm_led;
    assign results.key_dropped   = dropped_reg;
    assign results.entered_count = entered_reg;
    assign results.failure_count = status_reg.failure_count;

`ifndef ASSERT_OFF
    // An enter is either granted or denied, never both
    a_verdict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(granted_reg && denied_reg))
        else $error("granted and denied together");

    // A trigger leaves the alarm running; a lit LED needs a running alarm
    a_start_on: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (status_reg.alarm_started || status_reg.alarm_led)
        |-> status_reg.alarm_on)
        else $error("alarm flags without active alarm");

    // A dropped key means the store was already full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && dropped_reg |-> entered_reg == COUNT_W'(MAX_KEYS))
        else $error("key dropped with room left");

    // A processed item shows up on the result register next cycle
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("processed item lost");
`endif

endmodule

>>> design/kcl_entry.sv
module kcl_entry #(
    parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        mode,
    input  logic [kcl_pkg::KEY_W-1:0]   key_code,
    input  logic [kcl_pkg::CODE_W-1:0]  code_keys,
    input  logic [kcl_pkg::COUNT_W-1:0] code_length,
    output kcl_pkg::kcl_event_t         evt,
    output logic                        key_dropped,
    output logic [kcl_pkg::COUNT_W-1:0] entered_count
);
    import kcl_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int IDX_W = $clog2(MAX_KEYS);

    logic [KEY_W-1:0] entry_keys_reg [MAX_KEYS];
    logic [CNT_W-1:0] entry_len_reg;
    logic [CNT_W-1:0] entry_len_next;
    logic             is_enter;
    logic             is_clear;
    logic             is_append;
    logic             has_room;
    logic             match;

    assign is_enter  = (mode == MODE_KEY) && (key_code == KEY_ENTER);
    assign is_clear  = (mode == MODE_KEY) && (key_code == KEY_CLEAR);
    assign is_append = (mode == MODE_KEY) && !is_enter && !is_clear;
    assign has_room  = entry_len_reg < CNT_W'(MAX_KEYS);

    // Entries past the current length are don't-care
    always_comb
    begin
        match = (COUNT_W'(entry_len_reg) == code_length);
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if ((CNT_W'(i) < entry_len_reg) && (entry_keys_reg[i] != code_keys[4*i +: 4]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        entry_len_next = entry_len_reg;
        if (is_enter || is_clear)
        begin
            entry_len_next = '0;
        end
        else if (is_append && has_room)
        begin
            entry_len_next = entry_len_reg + CNT_W'(1);
        end
    end

    assign evt.tick      = (mode == MODE_TICK);
    assign evt.granted   = is_enter && match;
    assign evt.denied    = is_enter && !match;
    assign key_dropped   = is_append && !has_room;
    assign entered_count = COUNT_W'(entry_len_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_len_reg <= '0;
        end
        else if (fire)
        begin
            entry_len_reg <= entry_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_append && has_room)
        begin
            entry_keys_reg[entry_len_reg[IDX_W-1:0]] <= key_code;
        end
    end

endmodule

>>> design/kcl_alarm.sv
module kcl_alarm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  kcl_pkg::kcl_event_t         evt,
    input  logic [kcl_pkg::FAIL_W-1:0]  attempt_limit,
    input  logic [kcl_pkg::BLINK_W-1:0] blink_ticks,
    input  logic [kcl_pkg::ALARM_W-1:0] alarm_ticks,
    output kcl_pkg::kcl_status_t        status
);
    import kcl_pkg::*;

    logic [FAIL_W-1:0]  failures_reg;
    logic [FAIL_W-1:0]  failures_next;
    logic               active_reg;
    logic               active_next;
    logic [ALARM_W-1:0] alarm_rem_reg;
    logic [ALARM_W-1:0] alarm_rem_next;
    logic [BLINK_W-1:0] blink_rem_reg;
    logic [BLINK_W-1:0] blink_rem_next;
    logic               led_reg;
    logic               led_next;
    logic               warn;
    logic               started;
    logic               ended;

    always_comb
    begin
        failures_next  = failures_reg;
        active_next    = active_reg;
        alarm_rem_next = alarm_rem_reg;
        blink_rem_next = blink_rem_reg;
        led_next       = led_reg;
        warn           = 1'b0;
        started        = 1'b0;
        ended          = 1'b0;
        // plain keys and clear leave the alarm side untouched
        if (evt.tick)
        begin
            if (active_reg)
            begin
                if (alarm_rem_reg <= ALARM_W'(1))
                begin
                    active_next    = 1'b0;
                    alarm_rem_next = '0;
                    blink_rem_next = '0;
                    led_next       = 1'b0;
                    ended          = 1'b1;
                end
                else
                begin
                    alarm_rem_next = alarm_rem_reg - ALARM_W'(1);
                    if (blink_rem_reg <= BLINK_W'(1))
                    begin
                        led_next       = !led_reg;
                        blink_rem_next = blink_ticks;
                    end
                    else
                    begin
                        blink_rem_next = blink_rem_reg - BLINK_W'(1);
                    end
                end
            end
        end
        else if (evt.granted)
        begin
            failures_next = '0;
            if (active_reg)
            begin
                active_next    = 1'b0;
                alarm_rem_next = '0;
                blink_rem_next = '0;
                led_next       = 1'b0;
                ended          = 1'b1;
            end
        end
        else if (evt.denied)
        begin
            if (failures_reg < FAIL_MAX)
            begin
                failures_next = failures_reg + FAIL_W'(1);
            end
            warn = (failures_next == FAIL_W'(1));
            // retrigger restarts both timers and the blink phase
            if (failures_next >= attempt_limit)
            begin
                active_next    = 1'b1;
                alarm_rem_next = alarm_ticks;
                blink_rem_next = blink_ticks;
                led_next       = 1'b0;
                started        = 1'b1;
            end
        end
    end

    assign status.first_warning = warn;
    assign status.alarm_started = started;
    assign status.alarm_ended   = ended;
    assign status.alarm_on      = active_next;
    assign status.alarm_led     = active_next && led_next;
    assign status.failure_count = failures_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failures_reg  <= '0;
            active_reg    <= 1'b0;
            alarm_rem_reg <= '0;
            blink_rem_reg <= '0;
            led_reg       <= 1'b0;
        end
        else if (fire)
        begin
            failures_reg  <= failures_next;
            active_reg    <= active_next;
            alarm_rem_reg <= alarm_rem_next;
            blink_rem_reg <= blink_rem_next;
            led_reg       <= led_next;
        end
    end

endmodule
